// ----- rtl/kcvpf_pkg.sv -----
// ----------------------------------------------------------------------------
// kcvpf_pkg
// Shared types and constants for the constant-velocity position filter.
// ----------------------------------------------------------------------------
package kcvpf_pkg;

    localparam int unsigned CFG_BITS = 31;
    localparam int unsigned IO_BITS  = 32;

    // register indexes
    localparam logic [1:0] REG_QP = 2'd0;
    localparam logic [1:0] REG_QV = 2'd1;
    localparam logic [1:0] REG_R  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV_SETUP,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    // ALU operation codes for the shared unit
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } t_op;

endpackage

// ----- rtl/kalman_cv_position_filter_top.sv -----
// ----------------------------------------------------------------------------
// kalman_cv_position_filter_top
// Two-state constant-velocity Kalman filter, signed fixed point, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carries one measured position word.
//   Output channel: o_valid / i_stall carries filtered position and velocity.
//   APB port writes Qp (0x0), Qv (0x4) and R (0x8); reads return them.
// Timing:
//   One word is handled at a time. A shared saturating add/sub unit and one
//   shared multiplier run under a step sequencer: 10 prediction steps (the
//   last two form S and the innovation), then a setup state and one divider
//   bit per cycle for each gain (WORD_BITS+FRAC_BITS bits each), then 14
//   multiply/add steps; each multiply's product is registered before use.
//   o_stall is high from acceptance until the result has been taken.
// Reset:
//   Synchronous, active low: state zero, covariance identity, registers to
//   their defaults. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module kalman_cv_position_filter_top
    import kcvpf_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_measured_position,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_filtered_position,
    output logic signed [31:0]  o_filtered_velocity
);

    localparam int unsigned W   = WORD_BITS;
    localparam int unsigned QB  = W + FRAC_BITS;        // quotient bits
    localparam int unsigned CW  = $clog2(QB + 1);
    localparam int unsigned PW  = 2 * W;
    typedef logic signed [W-1:0] t_word;

    localparam t_word WMAX = t_word'({1'b0, {(W-1){1'b1}}});
    localparam t_word WMIN = t_word'({1'b1, {(W-1){1'b0}}});
    localparam t_word ONE  = (FRAC_BITS <= W - 2) ? t_word'(1) <<< FRAC_BITS : WMAX;

    function automatic t_word sat_cfg(input logic [CFG_BITS-1:0] v);
        logic [CFG_BITS:0] e;
        begin
            e = {1'b0, v};
            if (W > CFG_BITS + 1) sat_cfg = t_word'(e);
            else if (e > (CFG_BITS+1)'(WMAX)) sat_cfg = WMAX;
            else sat_cfg = t_word'(e);
        end
    endfunction

    // ---------------- configuration ----------------
    logic [CFG_BITS-1:0] r_qp, r_qv, r_r;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qp <= CFG_BITS'(655);
            r_qv <= CFG_BITS'(655);
            r_r  <= CFG_BITS'(65536);
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_QP:  r_qp <= pwdata[CFG_BITS-1:0];
                REG_QV:  r_qv <= pwdata[CFG_BITS-1:0];
                REG_R:   r_r  <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_QP:  prdata = {1'b0, r_qp};
            REG_QV:  prdata = {1'b0, r_qv};
            REG_R:   prdata = {1'b0, r_r};
            default: prdata = '0;
        endcase
    end

    // ---------------- state and scratch registers ----------------
    t_word r_x0, r_x1, r_p00, r_p01, r_p10, r_p11;
    t_word r_z, r_xp0, r_pp00, r_pp01, r_pp10, r_pp11, r_s, r_k0, r_k1, r_y, r_omk;
    t_word r_tmp;
    t_state r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_ovalid;
    logic signed [31:0] r_opos, r_ovel;

    // ---------------- shared ALU ----------------
    t_op   alu_op;
    t_word alu_a, alu_b, alu_res;
    logic signed [PW-1:0] r_prod;
    logic signed [W:0]    sum_ext;

    function automatic t_word sat_ext(input logic signed [W:0] v);
        if (v[W] != v[W-1]) sat_ext = v[W] ? WMIN : WMAX;
        else sat_ext = v[W-1:0];
    endfunction

    function automatic t_word in_sat(input logic signed [31:0] v);
        if (W >= IO_BITS) in_sat = t_word'(v);
        else if (v > 32'(WMAX)) in_sat = WMAX;
        else if (v < 32'(WMIN)) in_sat = WMIN;
        else in_sat = t_word'(v);
    endfunction

    function automatic logic signed [31:0] out_clip(input t_word v);
        if (W <= IO_BITS) out_clip = 32'(v);
        else if (v > t_word'(32'sh7fffffff)) out_clip = 32'sh7fffffff;
        else if (v < t_word'(-33'sh80000000)) out_clip = 32'sh80000000;
        else out_clip = v[31:0];
    endfunction

    // rounded, saturated product from the registered exact product
    logic [PW-1:0] pmag, prnd;
    logic          pneg;
    t_word         mul_res;
    always_comb begin
        pneg = r_prod[PW-1];
        pmag = pneg ? PW'(-r_prod) : PW'(r_prod);
        prnd = (pmag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (pneg) begin
            if (prnd > PW'({1'b1, {(W-1){1'b0}}})) mul_res = WMIN;
            else mul_res = t_word'(-prnd[W-1:0]);
        end else begin
            if (prnd > PW'(WMAX)) mul_res = WMAX;
            else mul_res = t_word'(prnd[W-1:0]);
        end
    end

    always_comb begin
        if (alu_op == OP_SUB) sum_ext = {alu_a[W-1], alu_a} - {alu_b[W-1], alu_b};
        else sum_ext = {alu_a[W-1], alu_a} + {alu_b[W-1], alu_b};
        alu_res = sat_ext(sum_ext);
    end

    // ---------------- divider ----------------
    logic [W:0]    r_rem;
    logic [QB-1:0] r_num, r_quo;
    logic [W-1:0]  r_den;
    logic          r_dneg, r_dsel;
    logic [CW-1:0] r_cnt;
    logic [W:0]    rem_sh, rem_sub;
    logic [QB-1:0] quo_nx;
    t_word         div_res;
    always_comb begin
        rem_sh  = {r_rem[W-1:0], r_num[QB-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        // gain taken on the last bit includes that bit
        quo_nx  = {r_quo[QB-2:0], ~rem_sub[W]};
        if (r_dneg) begin
            if (quo_nx > QB'({1'b1, {(W-1){1'b0}}})) div_res = WMIN;
            else div_res = t_word'(-quo_nx[W-1:0]);
        end else begin
            if (quo_nx > QB'(WMAX)) div_res = WMAX;
            else div_res = t_word'(quo_nx[W-1:0]);
        end
    end

    // ---------------- sequencer operand select ----------------
    always_comb begin
        alu_op = OP_ADD;
        alu_a  = r_tmp;
        alu_b  = r_tmp;
        if (r_state == ST_PRED) begin
            case (r_step)
                5'd0: begin alu_a = r_x0;  alu_b = r_x1; end
                5'd1: begin alu_a = r_p10; alu_b = r_p01; end
                5'd2: begin alu_a = r_p00; alu_b = r_tmp; end
                5'd3: begin alu_a = r_tmp; alu_b = r_p11; end
                5'd4: begin alu_a = r_tmp; alu_b = sat_cfg(r_qp); end
                5'd5: begin alu_a = r_p01; alu_b = r_p11; end
                5'd6: begin alu_a = r_p10; alu_b = r_p11; end
                5'd7: begin alu_a = r_p11; alu_b = sat_cfg(r_qv); end
                5'd8: begin alu_a = r_pp00; alu_b = sat_cfg(r_r); end
                default: begin alu_op = OP_SUB; alu_a = r_z; alu_b = r_xp0; end
            endcase
        end else if (r_state == ST_MUL) begin
            // odd steps fold the product into state or covariance; step 4 forms ONE - k0
            case (r_step)
                5'd1:  begin alu_a = r_xp0; alu_b = mul_res; end
                5'd3:  begin alu_a = r_x1;  alu_b = mul_res; end
                5'd4:  begin alu_op = OP_SUB; alu_a = ONE; alu_b = r_k0; end
                5'd11: begin alu_op = OP_SUB; alu_a = r_pp10; alu_b = mul_res; end
                5'd13: begin alu_op = OP_SUB; alu_a = r_pp11; alu_b = mul_res; end
                default: ;
            endcase
        end
    end

    // multiplier operand select
    t_word ma, mb;
    always_comb begin
        ma = r_k0; mb = r_y;
        case (r_step)
            5'd2:  begin ma = r_k1;  mb = r_y; end
            5'd6:  begin ma = r_omk; mb = r_pp00; end
            5'd8:  begin ma = r_omk; mb = r_pp01; end
            5'd10: begin ma = r_k1;  mb = r_pp00; end
            5'd12: begin ma = r_k1;  mb = r_pp01; end
            default: ;
        endcase
    end

    logic in_acc, out_acc;
    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = r_ovalid & ~i_stall;
    assign o_stall = (r_state != ST_IDLE) | r_ovalid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE:      if (in_acc) begin n_state = ST_PRED; n_step = '0; end
            ST_PRED: begin
                n_step = r_step + 5'd1;
                if (r_step == 5'd9) n_state = ST_DIV_SETUP;
            end
            ST_DIV_SETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CW'(1)) begin
                    if (r_dsel) begin n_state = ST_MUL; n_step = '0; end
                    else n_state = ST_DIV_SETUP;
                end
            end
            ST_MUL: begin
                n_step = r_step + 5'd1;
                if (r_step == 5'd13) n_state = ST_DONE;
            end
            ST_DONE:      if (!r_ovalid) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_dsel   <= 1'b0;
            r_x0 <= '0; r_x1 <= '0;
            r_p00 <= ONE; r_p01 <= '0; r_p10 <= '0; r_p11 <= ONE;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (out_acc) r_ovalid <= 1'b0;
            if (in_acc) begin
                r_z    <= in_sat(i_measured_position);
                r_dsel <= 1'b0;
            end
            if (r_state == ST_PRED) begin
                case (r_step)
                    5'd0: r_xp0 <= alu_res;
                    5'd5: r_pp01 <= alu_res;
                    5'd6: r_pp10 <= alu_res;
                    5'd7: r_pp11 <= alu_res;
                    5'd8: r_s <= alu_res;
                    5'd9: r_y <= alu_res;
                    default: r_tmp <= alu_res;
                endcase
                if (r_step == 5'd4) r_pp00 <= alu_res;
            end
            if (r_state == ST_DIV_SETUP) begin
                // numerator: pp00 first, pp10 second
                t_word nn;
                nn = r_dsel ? r_pp10 : r_pp00;
                r_dneg <= nn[W-1] ^ r_s[W-1];
                r_num  <= QB'(nn[W-1] ? -{1'b0, nn} : {1'b0, nn}) << FRAC_BITS;
                r_den  <= r_s[W-1] ? W'(-r_s) : W'(r_s);
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= CW'(QB);
            end
            if (r_state == ST_DIV) begin
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CW'(1);
                if (!rem_sub[W]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[QB-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[QB-2:0], 1'b0};
                end
            end
            if (r_state == ST_DIV && r_cnt == CW'(1)) begin
                // a zero denominator forces a zero gain
                if (!r_dsel) begin
                    r_k0 <= (r_s == '0) ? '0 : div_res;
                    r_dsel <= 1'b1;
                end else begin
                    r_k1 <= (r_s == '0) ? '0 : div_res;
                end
            end
            if (r_state == ST_MUL) begin
                if (!r_step[0]) r_prod <= PW'(ma) * PW'(mb);
                case (r_step)
                    5'd1:  r_x0  <= alu_res;
                    5'd3:  r_x1  <= alu_res;
                    5'd4:  r_omk <= alu_res;
                    5'd7:  r_p00 <= mul_res;
                    5'd9:  r_p01 <= mul_res;
                    5'd11: r_p10 <= alu_res;
                    5'd13: r_p11 <= alu_res;
                    default: ;
                endcase
            end
            if (r_state == ST_DONE && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_opos <= out_clip(r_x0);
                r_ovel <= out_clip(r_x1);
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_filtered_position = r_opos;
    assign o_filtered_velocity = r_ovel;

endmodule

// ----- rtl/kcvpf_checker.sv -----
// ----------------------------------------------------------------------------
// kcvpf_checker
// Port-level checks on the filter handshakes.
// ----------------------------------------------------------------------------
module kcvpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_filtered_position,
    input logic        pready
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered_position))
        else $error("result word changed under stall");

    // one word at a time: input closed while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // acceptance closes the input next cycle
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !o_valid)
        else $error("input not closed after accept");

    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind kalman_cv_position_filter_top kcvpf_checker u_kcvpf_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives measured positions through the constant-velocity position filter,
// predicts every filtered position/velocity pair with a fixed-point model of
// its own, and compares results in order. Noise registers are rewritten over
// the APB port between phases, including their extremes.
// ----------------------------------------------------------------------------
module testbench
    import kcvpf_pkg::*;
();

    localparam int  FRAC      = 16;
    localparam longint WMAX   = 64'sd2147483647;
    localparam longint WMIN   = -64'sd2147483648;
    localparam longint ONE_Q  = 64'sd65536;
    localparam int  LIMIT     = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_measured_position = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_filtered_position, o_filtered_velocity;

    kalman_cv_position_filter_top dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // filter state kept by the predictor
    longint est_pos, est_vel, p00, p01, p10, p11;
    longint noise_qp, noise_qv, noise_r;

    logic signed [31:0] pending_pos[$];
    logic signed [31:0] want_pos[$], want_vel[$];
    int errors = 0, mismatches = 0;
    int cycles = 0;

    function automatic longint clamp(longint v);
        return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
    endfunction

    // products and quotients fit in 128 bits before clamping
    function automatic longint qmul(longint a, longint b);
        logic signed [127:0] p;
        logic        [127:0] m;
        logic neg;
        p = 128'(signed'(a)) * 128'(signed'(b));
        neg = p[127];
        m = neg ? -p : p;
        m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
        if (neg) return (m > 128'd2147483648) ? WMIN : -longint'(m[63:0]);
        return (m > 128'd2147483647) ? WMAX : longint'(m[63:0]);
    endfunction

    function automatic longint qdiv(longint num, longint den);
        logic [127:0] un, ud, q;
        logic neg;
        neg = (num < 0) != (den < 0);
        un = (num < 0 ? -num : num);
        ud = (den < 0 ? -den : den);
        q = (un << FRAC) / ud;
        if (neg) return (q > 128'd2147483648) ? WMIN : -longint'(q[63:0]);
        return (q > 128'd2147483647) ? WMAX : longint'(q[63:0]);
    endfunction

    task automatic filter_step(input logic signed [31:0] z);
        longint xp0, xp1, q00, q01, q10, q11, s, k0, k1, y, omk;
        xp0 = clamp(est_pos + est_vel);
        xp1 = est_vel;
        q00 = clamp(p00 + clamp(p10 + p01));
        q00 = clamp(clamp(q00 + p11) + noise_qp);
        q01 = clamp(p01 + p11);
        q10 = clamp(p10 + p11);
        q11 = clamp(p11 + noise_qv);
        s = clamp(q00 + noise_r);
        k0 = 0;
        k1 = 0;
        if (s != 0) begin
            k0 = qdiv(q00, s);
            k1 = qdiv(q10, s);
        end
        y = clamp(longint'(z) - xp0);
        est_pos = clamp(xp0 + qmul(k0, y));
        est_vel = clamp(xp1 + qmul(k1, y));
        omk = clamp(ONE_Q - k0);
        p00 = qmul(omk, q00);
        p01 = qmul(omk, q01);
        p10 = clamp(q10 - qmul(k1, q00));
        p11 = clamp(q11 - qmul(k1, q01));
        want_pos.push_back(est_pos[31:0]);
        want_vel.push_back(est_vel[31:0]);
    endtask

    // sender: bursts and gaps
    int gap = 0, burst = 0;
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            filter_step(pending_pos.pop_front());
        end
        if (!(i_valid && o_stall)) begin
            if (gap > 0) begin
                gap <= gap - 1;
                i_valid <= 1'b0;
            end else if (i_rst_n && pending_pos.size() > 0) begin
                i_valid <= 1'b1;
                i_measured_position <= pending_pos[0];
                if (burst <= 0) begin
                    burst <= $urandom_range(1, 12);
                    gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                end else begin
                    burst <= burst - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, then compare
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (o_valid && !i_stall) begin
            if (want_pos.size() == 0) begin
                errors <= errors + 1;
                if (mismatches < 10) $display("unexpected word %h %h",
                    o_filtered_position, o_filtered_velocity);
                mismatches <= mismatches + 1;
            end else begin
                if (o_filtered_position !== want_pos[0] ||
                    o_filtered_velocity !== want_vel[0]) begin
                    errors <= errors + 1;
                    if (mismatches < 10)
                        $display("mismatch: want pos %h vel %h, got pos %h vel %h",
                            want_pos[0], want_vel[0], o_filtered_position,
                            o_filtered_velocity);
                    mismatches <= mismatches + 1;
                end
                void'(want_pos.pop_front());
                void'(want_vel.pop_front());
            end
        end
        case (cycles[9:8])
            2'd0:    i_stall <= 1'b0;
            2'd1:    i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
        if (cycles >= LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_QP:  noise_qp = longint'(value[30:0]);
            REG_QV:  noise_qv = longint'(value[30:0]);
            default: noise_r  = longint'(value[30:0]);
        endcase
    endtask

    task automatic drain();
        while (pending_pos.size() > 0 || i_valid || want_pos.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_noise();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 65536);
            3:       return $urandom;
            default: return $urandom_range(0, 2000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_meas(int trend, int k);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(trend * k + $signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    initial begin
        int trend;
        est_pos = 0; est_vel = 0; p00 = ONE_Q; p01 = 0; p10 = 0; p11 = ONE_Q;
        noise_qp = 655; noise_qv = 655; noise_r = 65536;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes at reset settings, then zero noise
        pending_pos.push_back(32'h0000_0000);
        pending_pos.push_back(32'h7FFF_FFFF);
        pending_pos.push_back(32'h8000_0000);
        pending_pos.push_back(32'hFFFF_FFFF);
        pending_pos.push_back(32'h0001_0000);
        pending_pos.push_back(32'h5555_5555);
        pending_pos.push_back(32'hAAAA_AAAA);
        for (int i = 0; i < 5; i++) pending_pos.push_back(32'(i * 32'h0002_0000));
        drain();
        // zero noise everywhere drives the innovation variance toward zero
        reg_write(REG_QP, 32'h0);
        reg_write(REG_QV, 32'h0);
        reg_write(REG_R, 32'h0);
        for (int i = 0; i < 8; i++) pending_pos.push_back(32'h0001_0000);
        drain();
        reg_write(REG_QP, 32'h7FFF_FFFF);
        reg_write(REG_QV, 32'hFFFF_FFFF);
        reg_write(REG_R, 32'h7FFF_FFFF);
        pending_pos.push_back(32'h7FFF_FFFF);
        pending_pos.push_back(32'h8000_0000);
        pending_pos.push_back(32'h1234_5678);
        drain();
        // random phases, each with fresh noise settings
        for (int ph = 0; ph < 25; ph++) begin
            reg_write(REG_QP, rand_noise());
            reg_write(REG_QV, rand_noise());
            reg_write(REG_R, ($urandom_range(0, 4) == 0) ? rand_noise()
                              : $urandom_range(1000, 600000));
            trend = $signed($urandom_range(0, 400000)) - 200000;
            for (int k = 0; k < 48; k++) pending_pos.push_back(rand_meas(trend, k));
            drain();
        end
        if (errors == 0 && want_pos.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
